/* hw/rtl/bxds_pkg.sv */
// ----------------------------------------------------------------------------
// bxds_pkg
// Shared types and constants for the 2x2 box-average RGB downscaler.
// ----------------------------------------------------------------------------
package bxds_pkg;

  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int CH_BITS       = 8;
  localparam int PAIR_BITS     = CH_BITS + 1;
  localparam int ROW_W         = 12;
  localparam int ROW_LIMIT     = 4096;
  localparam int MAX_WIDTH_DEF = 4096;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDX_WIDTH  = 1'b0,
    CFG_IDX_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PAIR_BITS-1:0] red;
    logic [PAIR_BITS-1:0] green;
    logic [PAIR_BITS-1:0] blue;
  } pair_sum_t;

  typedef struct packed {
    logic active;
    logic col_odd;
    logic row_odd;
    logic frame_last;
  } pos_info_t;

endpackage

/* hw/rtl/bxds_pos_ctrl.sv */
// ----------------------------------------------------------------------------
// bxds_pos_ctrl
// Frame size registers and column/row position tracking.
// ----------------------------------------------------------------------------
module bxds_pos_ctrl #(
  parameter int MAX_WIDTH  = bxds_pkg::MAX_WIDTH_DEF,
  parameter int LINE_DEPTH = MAX_WIDTH / 2,
  parameter int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bxds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bxds_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           accept,
  output bxds_pkg::pos_info_t            info,
  output logic [ADDR_W-1:0]              line_addr
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int MW_W       = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W      = (bxds_pkg::CFG_W > MW_W) ? bxds_pkg::CFG_W : MW_W;
  localparam int PAIR_IDX_W = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int RCMP_W     = bxds_pkg::ROW_W + 1;

  logic [bxds_pkg::CFG_W-1:0] width_r;
  logic [bxds_pkg::CFG_W-1:0] height_r;
  logic [COL_W-1:0]           col_r;
  logic [COL_W-1:0]           col_nxt;
  logic [bxds_pkg::ROW_W-1:0] row_r;
  logic [bxds_pkg::ROW_W-1:0] row_nxt;

  logic [CMP_W-1:0]           eff_w;
  logic [CMP_W-1:0]           wide_w;
  logic [RCMP_W-1:0]          eff_h;
  logic [COL_W-1:0]           cur_col;
  logic [bxds_pkg::ROW_W-1:0] cur_row;
  logic [CMP_W-1:0]           col_inc;
  logic [RCMP_W-1:0]          row_inc;
  logic [PAIR_IDX_W-1:0]      pair_idx;
  logic                       active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bxds_pkg::RESET_WIDTH;
      height_r <= bxds_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (bxds_pkg::cfg_idx_t'(cfg_index))
        bxds_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        bxds_pkg::CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    wide_w  = CMP_W'(width_r);
    eff_w   = (wide_w > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : wide_w;
    eff_h   = (RCMP_W'(height_r) > RCMP_W'(bxds_pkg::ROW_LIMIT)) ?
              RCMP_W'(bxds_pkg::ROW_LIMIT) : RCMP_W'(height_r);
    active  = (eff_w != '0) && (eff_h != '0);
    cur_col = (CMP_W'(col_r) >= eff_w) ? '0 : col_r;
    cur_row = (RCMP_W'(row_r) >= eff_h) ? '0 : row_r;
    col_inc = CMP_W'(cur_col) + CMP_W'(1);
    row_inc = RCMP_W'(cur_row) + RCMP_W'(1);

    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_h) ? '0 : row_inc[bxds_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = cur_row;
    end

    pair_idx  = PAIR_IDX_W'(cur_col >> 1);
    line_addr = (pair_idx > PAIR_IDX_W'(LINE_DEPTH - 1)) ?
                ADDR_W'(LINE_DEPTH - 1) : ADDR_W'(pair_idx);

    info.active     = active;
    info.col_odd    = cur_col[0];
    info.row_odd    = cur_row[0];
    info.frame_last = (col_inc == {eff_w[CMP_W-1:1], 1'b0}) &&
                      (row_inc == {eff_h[RCMP_W-1:1], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept && active) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* hw/rtl/bxds_line_mem.sv */
// ----------------------------------------------------------------------------
// bxds_line_mem
// Line buffer of horizontal pair sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module bxds_line_mem #(
  parameter int DEPTH  = bxds_pkg::MAX_WIDTH_DEF / 2,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output bxds_pkg::pair_sum_t   rd_data_r,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  bxds_pkg::pair_sum_t   wr_data
);

  bxds_pkg::pair_sum_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/bxds_avg_pipe.sv */
// ----------------------------------------------------------------------------
// bxds_avg_pipe
// Pair-sum stage, line buffer update and registered averaged output.
// ----------------------------------------------------------------------------
module bxds_avg_pipe #(
  parameter int ADDR_W = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  output logic                        hold,
  input  bxds_pkg::pixel_t            pix,
  input  bxds_pkg::pos_info_t         info,
  input  logic [ADDR_W-1:0]           addr,
  input  bxds_pkg::pair_sum_t         line_rd,
  output logic                        line_we,
  output logic [ADDR_W-1:0]           line_waddr,
  output bxds_pkg::pair_sum_t         line_wdata,
  input  logic                        out_stall,
  output logic                        out_valid,
  output bxds_pkg::pixel_t            out_pix,
  output logic                        out_last
);

  localparam int TOT_W = bxds_pkg::PAIR_BITS + 1;

  logic                       s1_valid_r;
  bxds_pkg::pixel_t           s1_pix_r;
  bxds_pkg::pos_info_t        s1_info_r;
  logic [ADDR_W-1:0]          s1_addr_r;
  bxds_pkg::pixel_t           pend_r;
  logic                       out_valid_r;
  bxds_pkg::pixel_t           out_pix_r;
  logic                       out_last_r;

  bxds_pkg::pair_sum_t        psum;
  bxds_pkg::pixel_t           avg;
  logic [TOT_W-1:0]           tot_r;
  logic [TOT_W-1:0]           tot_g;
  logic [TOT_W-1:0]           tot_b;
  logic                       emits;
  logic                       out_free;
  logic                       s1_go;

  always_comb begin
    psum.red   = bxds_pkg::PAIR_BITS'(pend_r.red)   + bxds_pkg::PAIR_BITS'(s1_pix_r.red);
    psum.green = bxds_pkg::PAIR_BITS'(pend_r.green) + bxds_pkg::PAIR_BITS'(s1_pix_r.green);
    psum.blue  = bxds_pkg::PAIR_BITS'(pend_r.blue)  + bxds_pkg::PAIR_BITS'(s1_pix_r.blue);
    tot_r      = TOT_W'(line_rd.red)   + TOT_W'(psum.red)   + TOT_W'(2);
    tot_g      = TOT_W'(line_rd.green) + TOT_W'(psum.green) + TOT_W'(2);
    tot_b      = TOT_W'(line_rd.blue)  + TOT_W'(psum.blue)  + TOT_W'(2);
    avg.red    = tot_r[TOT_W-1:2];
    avg.green  = tot_g[TOT_W-1:2];
    avg.blue   = tot_b[TOT_W-1:2];

    emits      = s1_valid_r && s1_info_r.col_odd && s1_info_r.row_odd;
    out_free   = !out_valid_r || !out_stall;
    s1_go      = s1_valid_r && (!emits || out_free);
    hold       = s1_valid_r && !s1_go;

    line_we    = s1_go && s1_info_r.col_odd && !s1_info_r.row_odd;
    line_waddr = s1_addr_r;
    line_wdata = psum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= info.active;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= pix;
      s1_info_r <= info;
      s1_addr_r <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (s1_go && !s1_info_r.col_odd) begin
      pend_r <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emits;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emits) begin
      out_pix_r  <= avg;
      out_last_r <= s1_info_r.frame_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

endmodule

/* hw/rtl/rgb_box_average_downscale_2x2.sv */
// ----------------------------------------------------------------------------
// rgb_box_average_downscale_2x2
// 2x2 box-average downscaler for a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// An accepted pixel is registered in stage 1 and its average at the output.
// Throughput: one pixel per cycle while out_stall is low, set by the
// single-port-pair line buffer, read on input and written one stage later.
// Reset (synchronous, rst_n low): position counters, pending pixel and valid
// flags clear; width/height return to 640/480. Line buffer is not cleared.
// ----------------------------------------------------------------------------
module rgb_box_average_downscale_2x2 #(
  parameter int MAX_WIDTH = bxds_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bxds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bxds_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bxds_pkg::CH_BITS-1:0]   in_pix_red,
  input  logic [bxds_pkg::CH_BITS-1:0]   in_pix_green,
  input  logic [bxds_pkg::CH_BITS-1:0]   in_pix_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bxds_pkg::CH_BITS-1:0]   out_avg_red,
  output logic [bxds_pkg::CH_BITS-1:0]   out_avg_green,
  output logic [bxds_pkg::CH_BITS-1:0]   out_avg_blue,
  output logic                           out_frame_end
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic                 accept;
  logic                 hold;
  bxds_pkg::pos_info_t  info;
  logic [ADDR_W-1:0]    addr;
  bxds_pkg::pixel_t     pix;
  bxds_pkg::pair_sum_t  line_rd;
  logic                 line_we;
  logic [ADDR_W-1:0]    line_waddr;
  bxds_pkg::pair_sum_t  line_wdata;
  bxds_pkg::pixel_t     out_pix;

  assign in_stall  = hold;
  assign accept    = in_valid && !hold;
  assign pix.red   = in_pix_red;
  assign pix.green = in_pix_green;
  assign pix.blue  = in_pix_blue;

  bxds_pos_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LINE_DEPTH (LINE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .info      (info),
    .line_addr (addr)
  );

  bxds_line_mem #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (addr),
    .rd_data_r (line_rd),
    .wr_en     (line_we),
    .wr_addr   (line_waddr),
    .wr_data   (line_wdata)
  );

  bxds_avg_pipe #(
    .ADDR_W (ADDR_W)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .hold       (hold),
    .pix        (pix),
    .info       (info),
    .addr       (addr),
    .line_rd    (line_rd),
    .line_we    (line_we),
    .line_waddr (line_waddr),
    .line_wdata (line_wdata),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_pix    (out_pix),
    .out_last   (out_frame_end)
  );

  assign out_avg_red   = out_pix.red;
  assign out_avg_green = out_pix.green;
  assign out_avg_blue  = out_pix.blue;

endmodule

/* tb/tb_rgb_box_average_downscale_2x2.sv */
// ----------------------------------------------------------------------------
// tb_rgb_box_average_downscale_2x2
// Self-checking bench for the 2x2 box-average RGB downscaler. A short table
// of directed pixels and size writes runs first. Random phases of pixels
// follow, with random frame sizes that change between phases; one phase is
// a long run with no idling. The width only changes while the row count is
// even, so an odd row always reads pair sums that its even row wrote.
// A behavioral model predicts every output transaction; directed pixels take
// their values from the table. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rgb_box_average_downscale_2x2;

  localparam int LIMIT      = 400000;
  localparam int RAND_ITEMS = 1100;
  localparam int LINE_DEPTH = bxds_pkg::MAX_WIDTH_DEF / 2;
  localparam int PLAN_N     = 22;
  localparam int CALM_PHASE = 8;
  localparam int CALM_ITEMS = 240;

  typedef struct packed {
    logic [bxds_pkg::CH_BITS-1:0] red;
    logic [bxds_pkg::CH_BITS-1:0] green;
    logic [bxds_pkg::CH_BITS-1:0] blue;
    logic                         frame_end;
  } box_mean_t;

  typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;

  typedef struct packed {
    step_kind_t                 kind;
    bxds_pkg::cfg_idx_t         reg_idx;
    logic [bxds_pkg::CFG_W-1:0] reg_val;
    bxds_pkg::pixel_t           px;
    logic                       typed;
    box_mean_t                  want;
  } step_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [bxds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bxds_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [bxds_pkg::CH_BITS-1:0]   in_pix_red = '0;
  logic [bxds_pkg::CH_BITS-1:0]   in_pix_green = '0;
  logic [bxds_pkg::CH_BITS-1:0]   in_pix_blue = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [bxds_pkg::CH_BITS-1:0]   out_avg_red;
  logic [bxds_pkg::CH_BITS-1:0]   out_avg_green;
  logic [bxds_pkg::CH_BITS-1:0]   out_avg_blue;
  logic                           out_frame_end;

  // model state
  logic [bxds_pkg::CFG_W-1:0] mdl_width = bxds_pkg::RESET_WIDTH;
  logic [bxds_pkg::CFG_W-1:0] mdl_height = bxds_pkg::RESET_HEIGHT;
  bxds_pkg::pair_sum_t        mdl_line [LINE_DEPTH];
  bxds_pkg::pixel_t           mdl_pending = '0;
  int                         mdl_col = 0;
  int                         mdl_row = 0;

  box_mean_t mean_q [$];
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  step_t     plan [PLAN_N];

  rgb_box_average_downscale_2x2 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pix_red   (in_pix_red),
    .in_pix_green (in_pix_green),
    .in_pix_blue  (in_pix_blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_avg_red  (out_avg_red),
    .out_avg_green(out_avg_green),
    .out_avg_blue (out_avg_blue),
    .out_frame_end(out_frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);
  end

  function automatic bit box_predict(input bxds_pkg::pixel_t px, output box_mean_t m);
    int                  w;
    int                  h;
    int                  p;
    bxds_pkg::pair_sum_t ps;
    box_predict = 1'b0;
    m = '0;
    if (mdl_width != 0 && mdl_height != 0) begin
      w = (mdl_width > bxds_pkg::MAX_WIDTH_DEF) ? bxds_pkg::MAX_WIDTH_DEF : int'(mdl_width);
      h = (mdl_height > bxds_pkg::ROW_LIMIT) ? bxds_pkg::ROW_LIMIT : int'(mdl_height);
      if (mdl_col >= w) mdl_col = 0;
      if (mdl_row >= h) mdl_row = 0;
      p = mdl_col >> 1;
      if (p >= LINE_DEPTH) p = LINE_DEPTH - 1;
      if ((mdl_col & 1) == 0) begin
        mdl_pending = px;
      end else begin
        ps.red   = bxds_pkg::PAIR_BITS'(mdl_pending.red) + bxds_pkg::PAIR_BITS'(px.red);
        ps.green = bxds_pkg::PAIR_BITS'(mdl_pending.green) + bxds_pkg::PAIR_BITS'(px.green);
        ps.blue  = bxds_pkg::PAIR_BITS'(mdl_pending.blue) + bxds_pkg::PAIR_BITS'(px.blue);
        if ((mdl_row & 1) == 0) begin
          mdl_line[p] = ps;
        end else begin
          m.red   = bxds_pkg::CH_BITS'((int'(mdl_line[p].red) + int'(ps.red) + 2) >> 2);
          m.green = bxds_pkg::CH_BITS'((int'(mdl_line[p].green) + int'(ps.green) + 2) >> 2);
          m.blue  = bxds_pkg::CH_BITS'((int'(mdl_line[p].blue) + int'(ps.blue) + 2) >> 2);
          m.frame_end = (mdl_col + 1 == (w & ~1)) && (mdl_row + 1 == (h & ~1));
          box_predict = 1'b1;
        end
      end
      mdl_col++;
      if (mdl_col >= w) begin
        mdl_col = 0;
        mdl_row++;
        if (mdl_row >= h) mdl_row = 0;
      end
    end
  endfunction

  function automatic step_t cfg_row(input bxds_pkg::cfg_idx_t idx, input int val);
    step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.reg_val = bxds_pkg::CFG_W'(val);
    return s;
  endfunction

  function automatic step_t pix_row(input int r, input int g, input int b);
    step_t s;
    s = '0;
    s.kind = STEP_PIX;
    s.px.red = bxds_pkg::CH_BITS'(r);
    s.px.green = bxds_pkg::CH_BITS'(g);
    s.px.blue = bxds_pkg::CH_BITS'(b);
    return s;
  endfunction

  function automatic step_t chk_row(input int r, input int g, input int b,
                                    input int er, input int eg, input int eb,
                                    input int ef);
    step_t s;
    s = pix_row(r, g, b);
    s.typed = 1'b1;
    s.want.red = bxds_pkg::CH_BITS'(er);
    s.want.green = bxds_pkg::CH_BITS'(eg);
    s.want.blue = bxds_pkg::CH_BITS'(eb);
    s.want.frame_end = ef[0];
    return s;
  endfunction

  function automatic logic [bxds_pkg::CH_BITS-1:0] rand_sample();
    if ($urandom_range(9) == 0) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    return bxds_pkg::CH_BITS'($urandom_range(255));
  endfunction

  task automatic send_pixel(input bxds_pkg::pixel_t px, input bit typed,
                            input box_mean_t want);
    box_mean_t m;
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pix_red <= px.red;
    in_pix_green <= px.green;
    in_pix_blue <= px.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (box_predict(px, m)) mean_q.push_back(typed ? want : m);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bxds_pkg::cfg_idx_t idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= bxds_pkg::CFG_W'(val);
    @(posedge clk);
    if (idx == bxds_pkg::CFG_IDX_WIDTH) mdl_width = bxds_pkg::CFG_W'(val);
    else mdl_height = bxds_pkg::CFG_W'(val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    box_mean_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none actual %0d/%0d/%0d/%0d",
                 $time, out_avg_red, out_avg_green, out_avg_blue, out_frame_end);
      end else begin
        want = mean_q.pop_front();
        check_field("red", want.red, out_avg_red);
        check_field("green", want.green, out_avg_green);
        check_field("blue", want.blue, out_avg_blue);
        check_field("frame_end", want.frame_end, out_frame_end);
      end
    end
  end

  initial begin : stimulus
    int               active_items;
    int               n;
    int               v;
    int               phase;
    bxds_pkg::pixel_t px;
    plan = '{
      cfg_row(bxds_pkg::CFG_IDX_WIDTH, 4),
      cfg_row(bxds_pkg::CFG_IDX_HEIGHT, 2),
      pix_row(255, 0, 255),
      pix_row(255, 0, 255),
      pix_row(0, 255, 0),
      pix_row(0, 255, 0),
      pix_row(255, 0, 255),
      chk_row(255, 0, 255, 255, 0, 255, 0),
      pix_row(0, 255, 0),
      chk_row(0, 255, 0, 0, 255, 0, 1),
      // rounding, half up
      pix_row(1, 2, 3),
      pix_row(0, 0, 3),
      pix_row(1, 1, 1),
      pix_row(1, 1, 1),
      pix_row(0, 0, 0),
      chk_row(0, 0, 0, 0, 1, 2, 0),
      pix_row(1, 1, 1),
      chk_row(0, 1, 2, 1, 1, 1, 1),
      // zero width: pixels ignored
      cfg_row(bxds_pkg::CFG_IDX_WIDTH, 0),
      pix_row(255, 255, 255),
      pix_row(0, 0, 0),
      cfg_row(bxds_pkg::CFG_IDX_WIDTH, 4)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        settle();
        write_reg(plan[i].reg_idx, int'(plan[i].reg_val));
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    active_items = 0;
    phase = 0;
    while (active_items < RAND_ITEMS) begin
      settle();
      if ($urandom_range(15) == 0) begin
        if ($urandom_range(1) != 0 && (mdl_row & 1) == 0)
          write_reg(bxds_pkg::CFG_IDX_WIDTH, 0);
        else write_reg(bxds_pkg::CFG_IDX_HEIGHT, 0);
      end else begin
        if (mdl_width == 0 || ((mdl_row & 1) == 0 && $urandom_range(2) != 0)) begin
          case ($urandom_range(23))
            0:       v = bxds_pkg::MAX_WIDTH_DEF;
            1:       v = 8191;
            2:       v = $urandom_range(13, 80);
            default: v = $urandom_range(1, 12);
          endcase
          write_reg(bxds_pkg::CFG_IDX_WIDTH, v);
        end
        if (mdl_height == 0 || $urandom_range(2) != 0) begin
          case ($urandom_range(23))
            0:       v = bxds_pkg::ROW_LIMIT;
            1:       v = 8191;
            default: v = $urandom_range(1, 8);
          endcase
          write_reg(bxds_pkg::CFG_IDX_HEIGHT, v);
        end
      end
      // one long phase with no idling on either side
      calm = (phase == CALM_PHASE);
      n = calm ? CALM_ITEMS : $urandom_range(1, 60);
      repeat (n) begin
        px.red = rand_sample();
        px.green = rand_sample();
        px.blue = rand_sample();
        send_pixel(px, 1'b0, '0);
        if (mdl_width != 0 && mdl_height != 0) active_items++;
      end
      calm = 1'b0;
      phase++;
    end

    settle();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
